FILE: src/lcwf_pkg.sv
package lcwf_pkg;

	localparam int CODE_W = 16;
	localparam int WEIGHT_W = 23;
	localparam int CAL_MARGIN = 10;
	localparam logic [WEIGHT_W-1:0] FULL_Q16 = 23'd6553600;
	localparam logic [13:0] FAST_GAIN = 14'd13107;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FAIL   = 2'd1,
		OP_TARE   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_ZERO_CODE = 1'b0,
		REG_FULL_CODE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] adc_code;
	} in_item_t;

	typedef struct packed {
		logic [22:0] fast_weight;
		logic [22:0] slow_weight;
		logic [22:0] tare_weight;
		logic        valid_res;
	} out_item_t;

	// request classified by the front part
	typedef struct packed {
		logic [1:0]  opcode;
		logic        bad_cal;
		logic [15:0] delta;
		logic [15:0] span;
	} cmd_t;

endpackage

FILE: src/lcwf_front.sv
module lcwf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lcwf_pkg::in_item_t in_data,
	input  logic [15:0]       zero_code,
	input  logic [15:0]       full_code,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output lcwf_pkg::cmd_t    cmd_data
);
	import lcwf_pkg::*;

	cmd_t       cmd_w;
	cmd_t       q_mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify request: calibration check and code offset
	always_comb begin
		cmd_w.opcode  = in_data.opcode;
		cmd_w.bad_cal = ({1'b0, full_code} <= ({1'b0, zero_code} + 17'(CAL_MARGIN)));
		cmd_w.span    = full_code - zero_code;
		cmd_w.delta   = (in_data.adc_code > zero_code) ? (in_data.adc_code - zero_code) : '0;
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_data  = q_mem_q[rd_q];

	// two-entry queue to the back part
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= cmd_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_pop) |=> in_stall) else $error("full queue not stalled");

endmodule

FILE: src/lcwf_div.sv
module lcwf_div #(
	parameter int NUM_W = 39,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0]   r_q;
	logic [DEN_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign trial = {r_q[DEN_W-1:0], q_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			q_q <= {q_q[NUM_W-2:0], ge};
			r_q <= ge ? (trial - {1'b0, d_q}) : trial;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;

endmodule

FILE: src/lcwf_back.sv
module lcwf_back #(
	parameter int WINDOW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  lcwf_pkg::cmd_t      cmd_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lcwf_pkg::out_item_t out_data
);
	import lcwf_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = WEIGHT_W + CNT_W;
	localparam int NUM_W = 39;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAP, ST_IIR, ST_READ, ST_SUM, ST_AVG, ST_OUT
	} st_t;

	st_t st_q, st_d;

	logic [WEIGHT_W-1:0] mem_q [WINDOW];
	logic [WINDOW-1:0]   wvalid_q;
	logic [WEIGHT_W-1:0] old_q;
	logic [IDX_W-1:0]    slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [WEIGHT_W-1:0] fast_q, slow_q, tare_q, x_q;
	logic                vflag_q;
	cmd_t                cmd_q;
	logic                ovld_q;
	out_item_t           odata_q;

	logic             dstart;
	logic [NUM_W-1:0] dnum;
	logic [NUM_W-1:0] dden;
	logic             dbusy, ddone;
	logic [NUM_W-1:0] dquot;
	logic [NUM_W-1:0] mul_w;
	logic signed [24:0] diff;
	logic signed [39:0] prod;
	logic signed [24:0] step;

	lcwf_div #(.NUM_W(NUM_W), .DEN_W(NUM_W)) u_div (
		.clk, .arst_n, .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quot(dquot)
	);

	// scale offset by full range
	assign mul_w = NUM_W'(cmd_q.delta) * NUM_W'(FULL_Q16);
	// iir step, arithmetic shift floors toward minus infinity
	assign diff = 25'(x_q) - 25'(fast_q);
	assign prod = 40'(diff) * 40'(signed'({1'b0, FAST_GAIN}));
	assign step = 25'(prod >>> 16);

	// sequencer next state
	always_comb begin
		st_d    = st_q;
		cmd_pop = 1'b0;
		dstart  = 1'b0;
		dnum    = mul_w;
		dden    = NUM_W'(cmd_q.span);
		unique case (st_q)
			ST_IDLE: if (cmd_valid && !ovld_q) begin
				cmd_pop = 1'b1;
				st_d    = ST_MAP;
			end
			ST_MAP: begin
				if (cmd_q.opcode != OP_SAMPLE) st_d = ST_OUT;
				else if (cmd_q.bad_cal || cmd_q.delta == 16'd0) st_d = ST_IIR;
				else if (!dbusy && !ddone) dstart = 1'b1;
				else if (ddone) st_d = ST_IIR;
			end
			ST_IIR:  st_d = ST_READ;
			ST_READ: st_d = ST_SUM;
			ST_SUM: begin
				dstart = 1'b1;
				st_d   = ST_AVG;
			end
			ST_AVG: if (ddone) st_d = ST_OUT;
			ST_OUT:  st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (st_q == ST_SUM) begin
			dnum = NUM_W'(sum_q);
			dden = NUM_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			wvalid_q <= '0;
			slot_q   <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			fast_q   <= '0;
			slow_q   <= '0;
			tare_q   <= '0;
			vflag_q  <= 1'b0;
			ovld_q   <= 1'b0;
			x_q      <= '0;
		end else begin
			st_q <= st_d;
			if (ovld_q && !out_stall) ovld_q <= 1'b0;
			unique case (st_q)
				ST_MAP: if (cmd_q.opcode == OP_SAMPLE) begin
					if (cmd_q.bad_cal || cmd_q.delta == 16'd0) x_q <= '0;
					else if (ddone)
						x_q <= (dquot > NUM_W'(FULL_Q16)) ? FULL_Q16 : dquot[WEIGHT_W-1:0];
				end
				ST_IIR: fast_q <= WEIGHT_W'(25'(fast_q) + step);
				ST_READ: begin
					sum_q <= sum_q - (wvalid_q[slot_q] ? SUM_W'(old_q) : '0) + SUM_W'(x_q);
					wvalid_q[slot_q] <= 1'b1;
					slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (fill_q != CNT_W'(WINDOW)) fill_q <= fill_q + 1'b1;
				end
				ST_AVG: if (ddone) begin
					slow_q  <= dquot[WEIGHT_W-1:0];
					vflag_q <= 1'b1;
				end
				ST_OUT: begin
					if (cmd_q.opcode == OP_FAIL) vflag_q <= 1'b0;
					if (cmd_q.opcode == OP_TARE) tare_q <= fast_q;
					ovld_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// window memory, registered read of the slot being replaced
	always_ff @(posedge clk) begin
		if (st_q == ST_IIR) old_q <= mem_q[slot_q];
		if (st_q == ST_READ) mem_q[slot_q] <= x_q;
		if (cmd_pop) cmd_q <= cmd_data;
	end

	// output register
	always_ff @(posedge clk) begin
		if (st_q == ST_OUT) begin
			odata_q.fast_weight <= fast_q;
			odata_q.slow_weight <= slow_q;
			odata_q.tare_weight <= (cmd_q.opcode == OP_TARE) ? fast_q : tare_q;
			odata_q.valid_res   <= (cmd_q.opcode == OP_FAIL) ? 1'b0 : vflag_q;
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = odata_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW)) else $error("fill count overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && out_stall) |=> ovld_q) else $error("result dropped");
	a_fast_range: assert property (@(posedge clk) disable iff (!arst_n)
		fast_q <= FULL_Q16) else $error("fast weight out of range");
	a_avg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_AVG) |-> fill_q != '0) else $error("average of empty window");

endmodule

FILE: src/load_cell_weight_filter.sv
// Load-cell weight filter. Each request is a sample, a failed read or a tare
// command and gives one result with the IIR weight, the moving average over
// WINDOW samples, the tare weight and a read-valid flag, all in 1/65536 kg.
// A front stage checks calibration and queues up to two requests; the back
// sequencer does one request at a time. A sample goes through a bit-serial
// divider twice, once to map the code to weight and once to form the
// average. A code at or below zero_code, or a bad calibration, skips the
// first pass. Failed reads, tares and the unused opcode skip both passes.
// The next request starts only once the previous result has left the
// output register, so a stalled result holds up the input. zero_code and
// full_code must be written only while no request is in flight; the block
// itself does not enforce this.
module load_cell_weight_filter #(
	parameter int WINDOW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lcwf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lcwf_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import lcwf_pkg::*;

	logic [15:0] zero_q, full_q;
	logic        cmd_valid, cmd_pop;
	cmd_t        cmd_data;

	assign cfg_ready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= '0;
			full_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_ZERO_CODE: zero_q <= cfg_data;
				REG_FULL_CODE: full_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lcwf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.zero_code(zero_q), .full_code(full_q),
		.cmd_valid, .cmd_pop, .cmd_data
	);

	lcwf_back #(.WINDOW(WINDOW)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_pop, .cmd_data,
		.out_valid, .out_stall, .out_data
	);

endmodule
